// ===== sv/cl_pkg.sv =====
// cl_pkg: shared types, codes and default sizes for the cell list binning block
// no dependencies; imported by every module of the block except cl_ram
package cl_pkg;

   localparam int COORD_W    = 24;
   localparam int INV_W      = 16;
   localparam int LAST_W     = 5;
   localparam int FIELD_W    = 13;
   localparam int STATUS_W   = 2;
   localparam int REQ_W      = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int CMD_BOX_W  = 24;

   localparam int DEF_MAX_POINTS = 4096;
   localparam int DEF_AXIS_CELLS = 32;

   localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd0;
   localparam logic [REQ_W-1:0] REQ_ADD    = 3'd1;
   localparam logic [REQ_W-1:0] REQ_BUILD  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd3;
   localparam logic [REQ_W-1:0] REQ_LIST   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_BUILT = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_CELL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_X   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_Y   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_Z   = 3'd6;

   typedef struct packed {
      logic [REQ_W-1:0]          req_type;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
      logic [LAST_W-1:0]         box_x;
      logic [LAST_W-1:0]         box_y;
      logic [LAST_W-1:0]         box_z;
      logic [FIELD_W-1:0]        list_pos;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FIELD_W-1:0]  box_start;
      logic [FIELD_W-1:0]  box_end;
      logic [FIELD_W-1:0]  point_id;
   } rsp_word_type;

   typedef struct packed {
      logic [REQ_W-1:0]     op;
      logic                 in_grid;
      logic                 range_ok;
      logic [CMD_BOX_W-1:0] box;
      logic [FIELD_W-1:0]   list_pos;
   } cmd_word_type;

endpackage

// ===== sv/cl_ram.sv =====
// cl_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module cl_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 4096
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== sv/cl_front.sv =====
// cl_front: config registers, box mapping pipeline and command classification
// depends on cl_pkg
module cl_front #(
   parameter int AXIS_CELLS = cl_pkg::DEF_AXIS_CELLS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [cl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cl_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  cl_pkg::req_word_type           req_word,
   output logic                           cmd_push,
   output cl_pkg::cmd_word_type           cmd_word,
   input  logic                           cmd_full
);
   import cl_pkg::*;

   localparam int AW    = $clog2(AXIS_CELLS);
   localparam int BW    = $clog2(AXIS_CELLS * AXIS_CELLS * AXIS_CELLS);
   localparam int LIM_W = (AW > LAST_W) ? AW : LAST_W;

   logic signed [COORD_W-1:0] org_x_ff, org_y_ff, org_z_ff;
   logic signed [COORD_W-1:0] org_x_in, org_y_in, org_z_in;
   logic [INV_W-1:0]          inv_ff, inv_in;
   logic [LAST_W-1:0]         last_x_ff, last_y_ff, last_z_ff;
   logic [LAST_W-1:0]         last_x_in, last_y_in, last_z_in;

   logic                      s1_valid_ff, s1_valid_in;
   req_word_type              s1_word_ff, s1_word_in;
   logic signed [COORD_W:0]   dx_ff, dy_ff, dz_ff, dx_in, dy_in, dz_in;
   logic                      s2_valid_ff, s2_valid_in;
   req_word_type              s2_word_ff, s2_word_in;
   logic signed [41:0]        px_ff, py_ff, pz_ff, px_in, py_in, pz_in;

   logic                      advance;
   logic [LIM_W-1:0]          lim_x, lim_y, lim_z;
   logic                      in_grid, range_ok;
   logic [BW-1:0]             pbox, lbox;

   function automatic logic axis_in(input logic signed [41:0] p, input logic [LIM_W-1:0] lim);
      axis_in = !p[41] && (p[41:16] <= 26'(lim));
   endfunction

   function automatic logic [LIM_W-1:0] axis_lim(input logic [LAST_W-1:0] last);
      axis_lim = (LIM_W'(last) < LIM_W'(AXIS_CELLS - 1)) ? LIM_W'(last)
                                                          : LIM_W'(AXIS_CELLS - 1);
   endfunction

   // config
   always_comb begin
      org_x_in  = org_x_ff;
      org_y_in  = org_y_ff;
      org_z_in  = org_z_ff;
      inv_in    = inv_ff;
      last_x_in = last_x_ff;
      last_y_in = last_y_ff;
      last_z_in = last_z_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_ORIGIN_X: org_x_in  = $signed(csr_wdata);
            CSR_ORIGIN_Y: org_y_in  = $signed(csr_wdata);
            CSR_ORIGIN_Z: org_z_in  = $signed(csr_wdata);
            CSR_INV_CELL: inv_in    = csr_wdata[INV_W-1:0];
            CSR_LAST_X:   last_x_in = csr_wdata[LAST_W-1:0];
            CSR_LAST_Y:   last_y_in = csr_wdata[LAST_W-1:0];
            CSR_LAST_Z:   last_z_in = csr_wdata[LAST_W-1:0];
            default: ;
         endcase
      end
   end

   // two stage mapping pipeline, stalled as a whole when the queue is full and stage two holds a word
   assign advance   = !s2_valid_ff || !cmd_full;
   assign req_stall = !advance;
   assign cmd_push  = s2_valid_ff && !cmd_full;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_word_in  = s1_word_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      dz_in       = dz_ff;
      s2_valid_in = s2_valid_ff;
      s2_word_in  = s2_word_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      pz_in       = pz_ff;
      if (advance) begin
         s1_valid_in = req_valid;
         s1_word_in  = req_word;
         dx_in = $signed({req_word.coord_x[COORD_W-1], req_word.coord_x})
               - $signed({org_x_ff[COORD_W-1], org_x_ff});
         dy_in = $signed({req_word.coord_y[COORD_W-1], req_word.coord_y})
               - $signed({org_y_ff[COORD_W-1], org_y_ff});
         dz_in = $signed({req_word.coord_z[COORD_W-1], req_word.coord_z})
               - $signed({org_z_ff[COORD_W-1], org_z_ff});
         s2_valid_in = s1_valid_ff;
         s2_word_in  = s1_word_ff;
         px_in = dx_ff * $signed({1'b0, inv_ff});
         py_in = dy_ff * $signed({1'b0, inv_ff});
         pz_in = dz_ff * $signed({1'b0, inv_ff});
      end
   end

   // classification
   always_comb begin
      lim_x    = axis_lim(last_x_ff);
      lim_y    = axis_lim(last_y_ff);
      lim_z    = axis_lim(last_z_ff);
      in_grid  = axis_in(px_ff, lim_x) && axis_in(py_ff, lim_y) && axis_in(pz_ff, lim_z);
      range_ok = (LIM_W'(s2_word_ff.box_x) <= lim_x) && (LIM_W'(s2_word_ff.box_y) <= lim_y)
              && (LIM_W'(s2_word_ff.box_z) <= lim_z);
      pbox = BW'(px_ff[16 +: AW]) * BW'(AXIS_CELLS * AXIS_CELLS)
           + BW'(py_ff[16 +: AW]) * BW'(AXIS_CELLS) + BW'(pz_ff[16 +: AW]);
      lbox = BW'(s2_word_ff.box_x) * BW'(AXIS_CELLS * AXIS_CELLS)
           + BW'(s2_word_ff.box_y) * BW'(AXIS_CELLS) + BW'(s2_word_ff.box_z);
      cmd_word.op       = s2_word_ff.req_type;
      cmd_word.in_grid  = in_grid;
      cmd_word.range_ok = range_ok;
      cmd_word.box      = CMD_BOX_W'((s2_word_ff.req_type == REQ_LOOKUP) ? lbox : pbox);
      cmd_word.list_pos = s2_word_ff.list_pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff    <= '0;
         org_y_ff    <= '0;
         org_z_ff    <= '0;
         inv_ff      <= INV_W'(256);
         last_x_ff   <= LAST_W'(31);
         last_y_ff   <= LAST_W'(31);
         last_z_ff   <= LAST_W'(31);
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         org_x_ff    <= org_x_in;
         org_y_ff    <= org_y_in;
         org_z_ff    <= org_z_in;
         inv_ff      <= inv_in;
         last_x_ff   <= last_x_in;
         last_y_ff   <= last_y_in;
         last_z_ff   <= last_z_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_word_ff <= s1_word_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      dz_ff      <= dz_in;
      s2_word_ff <= s2_word_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      pz_ff      <= pz_in;
   end
endmodule

// ===== sv/cl_fifo.sv =====
// cl_fifo: two entry command queue between front and back
// depends on cl_pkg
module cl_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cl_pkg::cmd_word_type push_word,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output cl_pkg::cmd_word_type head_word
);
   import cl_pkg::*;

   cmd_word_type slot_ff [2];
   cmd_word_type slot_in [2];
   logic         rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [1:0]   count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_word  = slot_ff[rd_ptr_ff];

   always_comb begin
      slot_in   = slot_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         slot_in[wr_ptr_ff] = push_word;
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end
endmodule

// ===== sv/cl_back.sv =====
// cl_back: command execution, point and box stores, build sequencer, result register
// depends on cl_pkg and cl_ram
module cl_back #(
   parameter int MAX_POINTS = cl_pkg::DEF_MAX_POINTS,
   parameter int AXIS_CELLS = cl_pkg::DEF_AXIS_CELLS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  cl_pkg::cmd_word_type cmd_word,
   output logic                 cmd_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cl_pkg::rsp_word_type rsp_word
);
   import cl_pkg::*;

   localparam int NB = AXIS_CELLS * AXIS_CELLS * AXIS_CELLS;
   localparam int BW = $clog2(NB);
   localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int LW = $clog2(MAX_POINTS + 1);
   localparam int SW = $clog2(MAX_POINTS + 2);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_RESULT  = 4'd1;
   localparam logic [3:0] S_LOOK    = 4'd2;
   localparam logic [3:0] S_LIST    = 4'd3;
   localparam logic [3:0] S_ZERO    = 4'd4;
   localparam logic [3:0] S_CNT_RD  = 4'd5;
   localparam logic [3:0] S_CNT_BOX = 4'd6;
   localparam logic [3:0] S_CNT_WR  = 4'd7;
   localparam logic [3:0] S_PRE_RD  = 4'd8;
   localparam logic [3:0] S_PRE_WR  = 4'd9;
   localparam logic [3:0] S_SC_RD   = 4'd10;
   localparam logic [3:0] S_SC_BOX  = 4'd11;
   localparam logic [3:0] S_SC_WR   = 4'd12;
   localparam logic [3:0] S_RS_RD   = 4'd13;
   localparam logic [3:0] S_RS_BOX  = 4'd14;
   localparam logic [3:0] S_RS_WR   = 4'd15;

   logic [3:0]    state_ff, state_in;
   logic [LW-1:0] loaded_ff, loaded_in, pi_ff, pi_in, pi_next;
   logic          built_ff, built_in;
   logic [BW-1:0] bi_ff, bi_in, box_ff, box_in;
   logic [SW-1:0] run_ff, run_in;
   rsp_word_type  res_ff, res_in, rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          last_box;

   logic          pb_we;
   logic [PW-1:0] pb_waddr, pb_raddr;
   logic [BW-1:0] pb_wdata, pb_rdata;
   logic          cnt_we;
   logic [BW-1:0] cnt_waddr, cnt_raddr;
   logic [SW-1:0] cnt_wdata, cnt_rdata;
   logic          st_we;
   logic [BW-1:0] st_waddr, st_raddr;
   logic [SW-1:0] st_wdata, st_rdata;
   logic          sl_we;
   logic [PW-1:0] sl_waddr, sl_raddr;
   logic [FIELD_W-1:0] sl_wdata, sl_rdata;

   cl_ram #(.WIDTH(BW), .DEPTH(MAX_POINTS)) u_point_box (
      .clock(clock), .wr_en(pb_we), .wr_addr(pb_waddr), .wr_data(pb_wdata),
      .rd_addr(pb_raddr), .rd_data(pb_rdata));
   cl_ram #(.WIDTH(SW), .DEPTH(NB)) u_box_end (
      .clock(clock), .wr_en(cnt_we), .wr_addr(cnt_waddr), .wr_data(cnt_wdata),
      .rd_addr(cnt_raddr), .rd_data(cnt_rdata));
   cl_ram #(.WIDTH(SW), .DEPTH(NB)) u_box_start (
      .clock(clock), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(st_wdata),
      .rd_addr(st_raddr), .rd_data(st_rdata));
   cl_ram #(.WIDTH(FIELD_W), .DEPTH(MAX_POINTS)) u_sorted (
      .clock(clock), .wr_en(sl_we), .wr_addr(sl_waddr), .wr_data(sl_wdata),
      .rd_addr(sl_raddr), .rd_data(sl_rdata));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign pi_next   = pi_ff + LW'(1);
   assign last_box  = (bi_ff == BW'(NB - 1));

   always_comb begin
      state_in     = state_ff;
      loaded_in    = loaded_ff;
      built_in     = built_ff;
      pi_in        = pi_ff;
      bi_in        = bi_ff;
      box_in       = box_ff;
      run_in       = run_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      pb_we        = 1'b0;
      pb_waddr     = loaded_ff[PW-1:0];
      pb_wdata     = cmd_word.box[BW-1:0];
      pb_raddr     = pi_ff[PW-1:0];
      cnt_we       = 1'b0;
      cnt_waddr    = bi_ff;
      cnt_wdata    = '0;
      cnt_raddr    = bi_ff;
      st_we        = 1'b0;
      st_waddr     = bi_ff;
      st_wdata     = SW'(1);
      st_raddr     = box_ff;
      sl_we        = 1'b0;
      sl_waddr     = PW'(st_rdata - SW'(1));
      sl_wdata     = FIELD_W'(pi_next);
      sl_raddr     = PW'(cmd_word.list_pos - FIELD_W'(1));
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               res_in   = '0;
               state_in = S_RESULT;
               case (cmd_word.op)
                  REQ_CLEAR: begin
                     loaded_in = '0;
                     built_in  = 1'b0;
                  end
                  REQ_ADD: begin
                     if (!cmd_word.in_grid) begin
                        res_in.status = ST_OUTSIDE;
                     end else if (loaded_ff == LW'(MAX_POINTS)) begin
                        res_in.status = ST_FULL;
                     end else begin
                        pb_we           = 1'b1;
                        loaded_in       = loaded_ff + LW'(1);
                        built_in        = 1'b0;
                        res_in.point_id = FIELD_W'(loaded_ff + LW'(1));
                     end
                  end
                  REQ_BUILD: begin
                     bi_in    = '0;
                     run_in   = '0;
                     state_in = S_ZERO;
                  end
                  REQ_LOOKUP: begin
                     if (!built_ff) begin
                        res_in.status = ST_NOT_BUILT;
                     end else if (!cmd_word.range_ok) begin
                        res_in.status = ST_OUTSIDE;
                     end else begin
                        cnt_raddr = cmd_word.box[BW-1:0];
                        st_raddr  = cmd_word.box[BW-1:0];
                        state_in  = S_LOOK;
                     end
                  end
                  REQ_LIST: begin
                     if (!built_ff || cmd_word.list_pos == '0
                         || 32'(cmd_word.list_pos) > 32'(loaded_ff)) begin
                        res_in.status = ST_NOT_BUILT;
                     end else begin
                        state_in = S_LIST;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_LOOK: begin
            res_in.box_start = FIELD_W'(st_rdata);
            res_in.box_end   = FIELD_W'(cnt_rdata);
            state_in         = S_RESULT;
         end
         S_LIST: begin
            res_in.point_id = sl_rdata;
            state_in        = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = S_IDLE;
            end
         end
         // build: zero counts, count points, prefix sum, scatter ids, restore starts
         S_ZERO: begin
            cnt_we = 1'b1;
            if (last_box) begin
               bi_in    = '0;
               pi_in    = '0;
               state_in = (loaded_ff == '0) ? S_PRE_RD : S_CNT_RD;
            end else begin
               bi_in = bi_ff + BW'(1);
            end
         end
         S_CNT_RD:  state_in = S_CNT_BOX;
         S_CNT_BOX: begin
            box_in    = pb_rdata;
            cnt_raddr = pb_rdata;
            state_in  = S_CNT_WR;
         end
         S_CNT_WR: begin
            cnt_we    = 1'b1;
            cnt_waddr = box_ff;
            cnt_wdata = cnt_rdata + SW'(1);
            pi_in     = pi_next;
            state_in  = (pi_next == loaded_ff) ? S_PRE_RD : S_CNT_RD;
         end
         S_PRE_RD:  state_in = S_PRE_WR;
         S_PRE_WR: begin
            st_we = 1'b1;
            if (cnt_rdata != '0) begin
               st_wdata  = run_ff + SW'(1);
               cnt_we    = 1'b1;
               cnt_wdata = run_ff + cnt_rdata;
               run_in    = run_ff + cnt_rdata;
            end
            if (last_box) begin
               pi_in = '0;
               if (loaded_ff == '0) begin
                  built_in = 1'b1;
                  state_in = S_RESULT;
               end else begin
                  state_in = S_SC_RD;
               end
            end else begin
               bi_in    = bi_ff + BW'(1);
               state_in = S_PRE_RD;
            end
         end
         S_SC_RD:  state_in = S_SC_BOX;
         S_SC_BOX: begin
            box_in   = pb_rdata;
            st_raddr = pb_rdata;
            state_in = S_SC_WR;
         end
         S_SC_WR: begin
            sl_we    = 1'b1;
            st_we    = 1'b1;
            st_waddr = box_ff;
            st_wdata = st_rdata + SW'(1);
            if (pi_next == loaded_ff) begin
               pi_in    = '0;
               state_in = S_RS_RD;
            end else begin
               pi_in    = pi_next;
               state_in = S_SC_RD;
            end
         end
         S_RS_RD:  state_in = S_RS_BOX;
         S_RS_BOX: begin
            box_in   = pb_rdata;
            st_raddr = pb_rdata;
            state_in = S_RS_WR;
         end
         S_RS_WR: begin
            st_we    = 1'b1;
            st_waddr = box_ff;
            st_wdata = st_rdata - SW'(1);
            pi_in    = pi_next;
            if (pi_next == loaded_ff) begin
               built_in = 1'b1;
               state_in = S_RESULT;
            end else begin
               state_in = S_RS_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         loaded_ff    <= '0;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         built_ff     <= built_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pi_ff  <= pi_in;
      bi_ff  <= bi_in;
      box_ff <= box_in;
      run_ff <= run_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end
endmodule

// ===== sv/cell_list_binning.sv =====
// cell_list_binning: point binning into grid boxes with a counting sort build.
// clear, add and other words: the back sequencer takes one word at a time and takes no
// new word until the last result is registered (lookup and list add a ram read state).
// build: walks the box and point rams one access a time.
// synchronous reset clears control state only; a build rewrites every box entry, so no
// clearing pass runs and words are taken right after reset
module cell_list_binning #(
   parameter int MAX_POINTS = cl_pkg::DEF_MAX_POINTS,
   parameter int AXIS_CELLS = cl_pkg::DEF_AXIS_CELLS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [cl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cl_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  cl_pkg::req_word_type          req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output cl_pkg::rsp_word_type          rsp_word
);
   import cl_pkg::*;

   logic         cmd_push, cmd_full, cmd_pop, cmd_valid;
   cmd_word_type cmd_in_word, cmd_head;

   cl_front #(.AXIS_CELLS(AXIS_CELLS)) u_front (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .cmd_push(cmd_push), .cmd_word(cmd_in_word), .cmd_full(cmd_full));

   cl_fifo u_queue (
      .clock(clock), .reset(reset),
      .push(cmd_push), .push_word(cmd_in_word), .full(cmd_full),
      .pop(cmd_pop), .head_valid(cmd_valid), .head_word(cmd_head));

   cl_back #(.MAX_POINTS(MAX_POINTS), .AXIS_CELLS(AXIS_CELLS)) u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(cmd_valid), .cmd_word(cmd_head), .cmd_pop(cmd_pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word));
endmodule

// ===== sv/cl_checker.sv =====
// cl_checker: port level checks for cell_list_binning, bound to the top level
// depends on cl_pkg
module cl_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input cl_pkg::rsp_word_type          rsp_word
);
   import cl_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != ST_OK |->
         rsp_word.box_start == '0 && rsp_word.box_end == '0 && rsp_word.point_id == '0)
      else $error("error word carries data");

   a_box_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.box_start != '0 |->
         14'(rsp_word.box_start) <= 14'(rsp_word.box_end) + 14'd1)
      else $error("box start past box end");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word right after reset");

   a_stall_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown(req_stall))
      else $error("input stall unknown");

endmodule

bind cell_list_binning cl_checker u_cl_checker (.*);
